// ===== rtl/jsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsp_pkg: shared types and constants of the json structure prescan
// Beat payload structs, configuration register indexes, character codes.
// ----------------------------------------------------------------------------
package jsp_pkg;

  // default width of the internal byte counter
  localparam int unsigned COUNT_WIDTH_DEF = 20;

  // field widths
  localparam int unsigned DEPTH_W  = 5;
  localparam int unsigned LENGTH_W = 20;
  localparam int unsigned MATCH_W  = 3;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_DEPTH  = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_idx_e;

  // register reset values
  localparam logic [DEPTH_W-1:0]  MAX_DEPTH_RST  = 5'd12;
  localparam logic [LENGTH_W-1:0] MAX_LENGTH_RST = 20'd65536;

  // saturation points
  localparam logic [DEPTH_W-1:0]  DEPTH_MAX = 5'd31;
  localparam logic [LENGTH_W-1:0] OUT_MAX   = 20'hFFFFF;

  // escape match progress: backslash, u, then four zeros
  localparam logic [MATCH_W-1:0] MATCH_IDLE  = 3'd0;
  localparam logic [MATCH_W-1:0] MATCH_BSL   = 3'd1;
  localparam logic [MATCH_W-1:0] MATCH_U     = 3'd2;
  localparam logic [MATCH_W-1:0] MATCH_LAST0 = 3'd5;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic                valid_res;
    logic [LENGTH_W-1:0] bytes_seen;
  } out_beat_t;

endpackage

// ===== rtl/json_structure_prescan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_structure_prescan: streaming structural check of json messages
// Tracks strings, escapes, bracket depth and length; one verdict per message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel takes one byte of the message per beat (in_valid_i,
//   in_stall_o, in_data_i); last_byte marks the final byte of a message.
//   One byte is taken every cycle unless in_stall_o is high; the per-byte
//   update of the string, escape, depth and counter state is a single
//   registered step, so with in_stall_o low the rate is one byte per cycle.
//   Only the last byte of a message yields a result beat (valid_res,
//   bytes_seen), presented on the cycle after that byte is taken, from an
//   output register. That register is the only buffer: while it holds a
//   result and out_stall_i is high, in_stall_o is high.
//   The configuration port writes max_depth (index 0) or max_length
//   (index 1) at any edge with cfg_we_i high; write only between messages.
//   Reset clears all message state and the output register and loads the
//   register defaults (max_depth 12, max_length 65536).
// ----------------------------------------------------------------------------
module json_structure_prescan #(
  parameter int unsigned COUNT_WIDTH = jsp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [jsp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jsp_pkg::CFG_W-1:0]      cfg_data_i,
  // input byte channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  jsp_pkg::in_beat_t              in_data_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output jsp_pkg::out_beat_t             out_data_o
);
  import jsp_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > LENGTH_W) ? COUNT_WIDTH : LENGTH_W;

  // configuration registers
  logic [DEPTH_W-1:0]  max_depth_q;
  logic [LENGTH_W-1:0] max_length_q;

  // message state
  logic                   in_string_q, in_string_d;
  logic                   escape_q, escape_d;
  logic [DEPTH_W-1:0]     depth_q, depth_d;
  logic [MATCH_W-1:0]     match_q, match_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   failed_q, failed_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_beat_t out_data_q, out_data_d;

  logic       in_fire;
  logic       in_last;
  logic [7:0] ch;
  logic       count_sat;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] count_next_ext;
  logic [CMP_W-1:0] max_len_ext;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign in_last    = in_data_i.last_byte;
  assign ch         = in_data_i.data_byte;

  assign count_sat      = &count_q;
  assign count_ext      = CMP_W'(count_q);
  assign count_next_ext = CMP_W'(count_d);
  assign max_len_ext    = CMP_W'(max_length_q);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_depth_q  <= MAX_DEPTH_RST;
      max_length_q <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_DEPTH:  max_depth_q  <= cfg_data_i[DEPTH_W-1:0];
        CFG_MAX_LENGTH: max_length_q <= cfg_data_i[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // per-byte state update
  always_comb begin
    failed_d    = failed_q;
    in_string_d = in_string_q;
    escape_d    = escape_q;
    depth_d     = depth_q;
    match_d     = match_q;

    // length check and saturating count
    if (count_ext >= max_len_ext || count_sat) begin
      failed_d = 1'b1;
    end
    count_d = count_sat ? count_q : count_q + COUNT_WIDTH'(1);

    if (ch == CH_NUL) begin
      failed_d = 1'b1;
    end

    // escaped nul sequence tracking
    if (match_q == MATCH_BSL) begin
      match_d = (ch == CH_U) ? MATCH_U : MATCH_IDLE;
    end else if (match_q >= MATCH_U) begin
      if (ch == CH_ZERO) begin
        if (match_q == MATCH_LAST0) begin
          failed_d = 1'b1;
          match_d  = MATCH_IDLE;
        end else begin
          match_d = match_q + MATCH_W'(1);
        end
      end else begin
        match_d = MATCH_IDLE;
      end
    end

    // string, escape and bracket tracking
    if (in_string_q) begin
      if (escape_q) begin
        escape_d = 1'b0;
      end else if (ch == CH_BSLASH) begin
        escape_d = 1'b1;
        match_d  = MATCH_BSL;
      end else if (ch == CH_QUOTE) begin
        in_string_d = 1'b0;
      end
    end else if (ch == CH_QUOTE) begin
      in_string_d = 1'b1;
    end else if (ch == CH_LBRACE || ch == CH_LBRACK) begin
      if ({1'b0, depth_q} + 6'd1 > {1'b0, max_depth_q}) begin
        failed_d = 1'b1;
      end
      if (depth_q < DEPTH_MAX) begin
        depth_d = depth_q + DEPTH_W'(1);
      end
    end else if (ch == CH_RBRACE || ch == CH_RBRACK) begin
      if (depth_q == '0) begin
        failed_d = 1'b1;
      end else begin
        depth_d = depth_q - DEPTH_W'(1);
      end
    end
  end

  // result beat
  always_comb begin
    out_data_d.valid_res  = ~failed_d & ~in_string_d & (depth_d == '0);
    out_data_d.bytes_seen = (count_next_ext > CMP_W'(OUT_MAX)) ? OUT_MAX
                                                                : count_next_ext[LENGTH_W-1:0];
    out_valid_d = out_valid_q & out_stall_i;
    if (in_fire && in_last) begin
      out_valid_d = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
      escape_q    <= 1'b0;
      depth_q     <= '0;
      match_q     <= MATCH_IDLE;
      count_q     <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        if (in_last) begin
          in_string_q <= 1'b0;
          escape_q    <= 1'b0;
          depth_q     <= '0;
          match_q     <= MATCH_IDLE;
          count_q     <= '0;
          failed_q    <= 1'b0;
        end else begin
          in_string_q <= in_string_d;
          escape_q    <= escape_d;
          depth_q     <= depth_d;
          match_q     <= match_d;
          count_q     <= count_d;
          failed_q    <= failed_d;
        end
      end
    end
  end

  // result payload, loaded with each last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_data_q <= '0;
    end else if (in_fire && in_last) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  // a taken last byte always produces a result beat
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_last |=> out_valid_q)
    else $error("last byte without result");

  // message state is cleared after the last byte
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_last |=> (count_q == '0) && !in_string_q && !failed_q && (depth_q == '0))
    else $error("message state not cleared");

  // an escape can only be pending inside a string
  a_escape_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    escape_q |-> in_string_q)
    else $error("escape pending outside string");

  // match progress never passes the last zero
  a_match_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q <= MATCH_LAST0)
    else $error("escape match out of range");

  // a stalled result is not overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !in_fire)
    else $error("result overwritten under stall");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the json structure prescan
// Streams directed and random json-like messages under several register
// settings and idling patterns; a scoreboard predicts every verdict beat.
// ----------------------------------------------------------------------------
module tb_top;
  import jsp_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASE_BYTES    = 110;
  localparam int NUM_PHASES     = 8;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PRESSURE_PHASE = 4;

  // predicts the verdict of each message from the accepted bytes
  class prescan_scoreboard;
    logic [DEPTH_W-1:0]  depth_limit;
    logic [LENGTH_W-1:0] length_limit;
    bit                  in_str;
    bit                  esc_pend;
    logic [DEPTH_W-1:0]  depth;
    logic [MATCH_W-1:0]  nul_match;
    logic [LENGTH_W-1:0] count;
    bit                  broken;
    out_beat_t           verdicts_due[$];
    int                  errors;
    int                  verdicts_checked;

    function new();
      depth_limit      = MAX_DEPTH_RST;
      length_limit     = MAX_LENGTH_RST;
      errors           = 0;
      verdicts_checked = 0;
      clear_message();
    endfunction

    function void clear_message();
      in_str    = 0;
      esc_pend  = 0;
      depth     = '0;
      nul_match = MATCH_IDLE;
      count     = '0;
      broken    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_MAX_DEPTH:  depth_limit  = val[DEPTH_W-1:0];
        CFG_MAX_LENGTH: length_limit = val[LENGTH_W-1:0];
        default: ;
      endcase
    endfunction

    function void absorb_byte(in_beat_t b);
      logic [7:0] ch;
      out_beat_t  v;
      ch = b.data_byte;
      // length limit, counter saturates
      if (count >= length_limit || count == OUT_MAX) broken = 1;
      if (count != OUT_MAX) count++;
      if (ch == CH_NUL) broken = 1;
      // progress of the escaped nul sequence
      if (nul_match == MATCH_BSL) begin
        nul_match = (ch == CH_U) ? MATCH_U : MATCH_IDLE;
      end else if (nul_match >= MATCH_U) begin
        if (ch != CH_ZERO) begin
          nul_match = MATCH_IDLE;
        end else if (nul_match == MATCH_LAST0) begin
          broken    = 1;
          nul_match = MATCH_IDLE;
        end else begin
          nul_match++;
        end
      end
      // string, escape and bracket tracking
      if (in_str) begin
        if (esc_pend) begin
          esc_pend = 0;
        end else if (ch == CH_BSLASH) begin
          esc_pend  = 1;
          nul_match = MATCH_BSL;
        end else if (ch == CH_QUOTE) begin
          in_str = 0;
        end
      end else if (ch == CH_QUOTE) begin
        in_str = 1;
      end else if (ch == CH_LBRACE || ch == CH_LBRACK) begin
        if ({1'b0, depth} + 6'd1 > {1'b0, depth_limit}) broken = 1;
        if (depth != DEPTH_MAX) depth++;
      end else if (ch == CH_RBRACE || ch == CH_RBRACK) begin
        if (depth == '0) broken = 1;
        else depth--;
      end
      // verdict on the last byte
      if (b.last_byte) begin
        v.valid_res  = !broken && !in_str && (depth == '0);
        v.bytes_seen = count;
        verdicts_due.push_back(v);
        clear_message();
      end
    endfunction

    function void check_verdict(out_beat_t got);
      out_beat_t want;
      if (verdicts_due.size() == 0) begin
        $error("unexpected result beat: valid_res %0d bytes_seen %0d",
               got.valid_res, got.bytes_seen);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      verdicts_checked++;
      if (got.valid_res !== want.valid_res) begin
        $error("valid_res: expected %0d, actual %0d", want.valid_res, got.valid_res);
        errors++;
      end
      if (got.bytes_seen !== want.bytes_seen) begin
        $error("bytes_seen: expected %0d, actual %0d", want.bytes_seen, got.bytes_seen);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we_i   = 1'b0;
  cfg_idx_e           cfg_idx_i  = CFG_MAX_DEPTH;
  logic [CFG_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_beat_t           in_data_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_beat_t          out_data_o;

  prescan_scoreboard  sb;
  logic [7:0]         msg_bytes[$];
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  bit                 hold_go        = 0;
  bit                 hold_used      = 0;
  int                 hold_left      = 0;
  int                 quiet_cycles   = 0;
  int                 bytes_in       = 0;

  json_structure_prescan uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_left = HOLD_CYCLES;
      hold_used = 1;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // beat monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.absorb_byte(in_data_i);
        bytes_in++;
      end
      if (out_valid_o && !out_stall_i) sb.check_verdict(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // watchdog on cycles without any beat
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk_i);
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("json_structure_prescan verification failed");
    $finish;
  end

  // offer one byte until it is taken; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {b, last};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // wait for every verdict, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // both registers, one write per cycle
  task automatic set_limits(input logic [CFG_W-1:0] max_d, input logic [CFG_W-1:0] max_l);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_DEPTH;
    cfg_data_i <= max_d;
    sb.write_reg(CFG_MAX_DEPTH, max_d);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_MAX_LENGTH;
    cfg_data_i <= max_l;
    sb.write_reg(CFG_MAX_LENGTH, max_l);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  // build one message: mostly json-like, some deep nests, noise and damage
  task automatic make_message(input int depth_cap, input int len_goal);
    int    kind;
    int    open_cnt;
    int    pick;
    int    pos;
    string fill;
    fill = "0123456789,:. tfnrue-";
    msg_bytes.delete();
    kind = $urandom_range(99);
    open_cnt = 0;
    if (kind < 10) begin
      // raw noise
      repeat ($urandom_range(1, len_goal)) msg_bytes.push_back(8'($urandom_range(255)));
    end else if (kind < 20) begin
      // nest right up to, or past, the depth limit
      repeat (depth_cap) msg_bytes.push_back($urandom_range(1) ? CH_LBRACE : CH_LBRACK);
      repeat (depth_cap) msg_bytes.push_back($urandom_range(1) ? CH_RBRACE : CH_RBRACK);
      if (msg_bytes.size() == 0) msg_bytes.push_back(fill[$urandom_range(fill.len() - 1)]);
    end else begin
      while (msg_bytes.size() < len_goal) begin
        pick = $urandom_range(9);
        if (pick < 2 && open_cnt < depth_cap) begin
          msg_bytes.push_back($urandom_range(1) ? CH_LBRACE : CH_LBRACK);
          open_cnt++;
        end else if (pick == 2 && open_cnt > 0) begin
          msg_bytes.push_back($urandom_range(1) ? CH_RBRACE : CH_RBRACK);
          open_cnt--;
        end else if (pick == 3) begin
          // string with escapes, some of them an escaped nul or part of one
          msg_bytes.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(7))
              0: begin
                msg_bytes.push_back(CH_BSLASH);
                case ($urandom_range(5))
                  0: begin
                    msg_bytes.push_back(CH_U);
                    repeat (4) msg_bytes.push_back(CH_ZERO);
                  end
                  1: begin
                    msg_bytes.push_back(CH_U);
                    repeat ($urandom_range(0, 3)) msg_bytes.push_back(CH_ZERO);
                    msg_bytes.push_back(fill[$urandom_range(fill.len() - 1)]);
                  end
                  2: msg_bytes.push_back(CH_QUOTE);
                  3: msg_bytes.push_back(CH_BSLASH);
                  default: msg_bytes.push_back(fill[$urandom_range(fill.len() - 1)]);
                endcase
              end
              1: msg_bytes.push_back(CH_ZERO);
              default: msg_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            endcase
          end
          if ($urandom_range(9) != 0) msg_bytes.push_back(CH_QUOTE);
        end else begin
          msg_bytes.push_back(fill[$urandom_range(fill.len() - 1)]);
        end
      end
      repeat (open_cnt) msg_bytes.push_back($urandom_range(1) ? CH_RBRACE : CH_RBRACK);
      // damage a share of the well-formed ones
      if (kind < 35) begin
        pos = $urandom_range(msg_bytes.size() - 1);
        case ($urandom_range(3))
          0: msg_bytes[pos] = 8'($urandom_range(255));
          1: msg_bytes.push_back($urandom_range(1) ? CH_RBRACE : CH_RBRACK);
          2: msg_bytes[pos] = CH_NUL;
          default: if (msg_bytes.size() > 1) void'(msg_bytes.pop_back());
        endcase
      end
    end
  endtask

  // stimulus
  initial begin
    int depth_set [NUM_PHASES];
    int len_set   [NUM_PHASES];
    int phase_sent;
    int cap;
    int goal;
    depth_set = '{31, 1, 0, 3, 12, 31, 7, 2};
    len_set   = '{1048575, 1, 0, 20, 65536, 8, 300, 40};
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed messages under the reset limits
    send_text("{}");
    send_text("]");
    send_text("\"\\u0000\"");
    send_text("\"\\\\\"");
    send_text("[");
    send_text("\"a");
    send_text("\"\\u00u\"");
    send_byte(CH_NUL, 1'b1);
    send_byte(8'hFF, 1'b1);
    drain();

    // random phases, one register setting and idling pattern each
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_limits(CFG_W'(depth_set[p]), CFG_W'(len_set[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (p == PRESSURE_PHASE) hold_go = 1;
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
        cap = $urandom_range(0, depth_set[p] + 2);
        if (len_set[p] < 40) goal = $urandom_range(1, len_set[p] + 3);
        else if ($urandom_range(19) == 0) goal = $urandom_range(40, 120);
        else goal = $urandom_range(1, 30);
        make_message(cap, goal);
        for (int i = 0; i < msg_bytes.size(); i++)
          send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        phase_sent += msg_bytes.size();
      end
      drain();
    end

    repeat (10) @(negedge clk_i);
    $display("run: %0d bytes, %0d verdicts checked, %0d register settings, 4 idling patterns",
             bytes_in, sb.verdicts_checked, NUM_PHASES + 1);
    $display("mismatches: %0d, verdicts outstanding: %0d", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("json_structure_prescan verification clean");
    end else begin
      $display("json_structure_prescan verification failed");
    end
    $finish;
  end

endmodule
